>>> hw/rtl/pip_pkg.sv
// Shared constants, register codes and control types of the point-in-polygon test.
package pip_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CFG_IDX_W       = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_LAT = 1'b0,
    REG_QUERY_LON = 1'b1
  } pip_reg_t;

  // Per-word control carried from the front end to the back end.
  // act[0]: edge from this vertex to the previous one straddles the query latitude.
  // act[1]: closing edge from the first vertex to this one straddles it.
  typedef struct packed {
    logic [1:0] act;
    logic       last;
  } pip_ctrl_t;

endpackage

>>> hw/rtl/pip_front.sv
// Front end: accepts vertex words, tracks first/previous vertex, forms edge operands.
module pip_front #(
  parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [COORD_WIDTH-2:0]      query_lat,
  input  logic signed [COORD_WIDTH-1:0]      query_lon,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_WIDTH-2:0]      vertex_lat,
  input  logic signed [COORD_WIDTH-1:0]      vertex_lon,
  input  logic                               last_vertex,
  input  logic                               q_full,
  output logic                               push,
  output logic [2*(4*COORD_WIDTH+2)-1:0]     push_data,
  output pip_pkg::pip_ctrl_t                 push_ctrl
);
  import pip_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int XW = CW + 1;

  logic signed [CW-2:0] start_lat;
  logic signed [CW-1:0] start_lon;
  logic signed [CW-2:0] prior_lat;
  logic signed [CW-1:0] prior_lon;
  logic                 have_start;
  logic                 fire;

  // edge A: a = this vertex, b = previous vertex
  logic signed [XW-1:0] xa, ya;
  logic signed [CW-1:0] dla, ela;
  logic                 strad_a;
  // edge B: a = first vertex, b = this vertex
  logic signed [XW-1:0] xb, yb;
  logic signed [CW-1:0] dlb, elb;
  logic                 strad_b;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign push     = fire;

  assign strad_a = (vertex_lat > query_lat) != (prior_lat > query_lat);
  assign xa      = XW'(query_lon) - XW'(vertex_lon);
  assign ya      = XW'(prior_lon) - XW'(vertex_lon);
  assign dla     = CW'(prior_lat) - CW'(vertex_lat);
  assign ela     = CW'(query_lat) - CW'(vertex_lat);

  assign strad_b = (start_lat > query_lat) != (vertex_lat > query_lat);
  assign xb      = XW'(query_lon) - XW'(start_lon);
  assign yb      = XW'(vertex_lon) - XW'(start_lon);
  assign dlb     = CW'(vertex_lat) - CW'(start_lat);
  assign elb     = CW'(query_lat) - CW'(start_lat);

  assign push_data     = {xb, yb, dlb, elb, xa, ya, dla, ela};
  assign push_ctrl.act = {have_start && last_vertex && strad_b, have_start && strad_a};
  assign push_ctrl.last = last_vertex;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_start <= 1'b0;
    end else if (fire) begin
      have_start <= !last_vertex;
    end
  end

  // start/prior only matter while have_start is set
  always_ff @(posedge clk) begin
    if (fire && !last_vertex) begin
      if (!have_start) begin
        start_lat <= vertex_lat;
        start_lon <= vertex_lon;
      end
      prior_lat <= vertex_lat;
      prior_lon <= vertex_lon;
    end
  end

`ifndef ASSERT_OFF
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire && last_vertex |=> !have_start)
    else $error("polygon state not cleared after last vertex");
`endif

endmodule

>>> hw/rtl/pip_queue.sv
// Short word queue between the front end and the back end.
module pip_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = pip_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [DATA_W-1:0]   push_data,
  input  pip_pkg::pip_ctrl_t  push_ctrl,
  output logic                full,
  input  logic                pop,
  output logic [DATA_W-1:0]   pop_data,
  output pip_pkg::pip_ctrl_t  pop_ctrl,
  output logic                empty
);
  import pip_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_data [DEPTH];
  pip_ctrl_t         mem_ctrl [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem_data[rd_ptr];
  assign pop_ctrl = mem_ctrl[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_data[wr_ptr] <= push_data;
      mem_ctrl[wr_ptr] <= push_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");
  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == CNT_W'($past(count) + 1'b1))
    else $error("queue count did not follow push");
`endif

endmodule

>>> hw/rtl/pip_back.sv
// Back end: exact cross-multiplied edge tests, crossing parity and result register.
module pip_back #(
  parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  output logic                            pop,
  input  logic [2*(4*COORD_WIDTH+2)-1:0]  pop_data,
  input  pip_pkg::pip_ctrl_t              pop_ctrl,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            inside_res
);
  import pip_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int XW     = CW + 1;
  localparam int H      = CW / 2;
  localparam int LW     = XW + H + 1;        // x * low half (zero-extended)
  localparam int HW     = XW + CW - H;       // x * high half (signed)
  localparam int PW     = 2 * CW + 1;        // full product
  localparam int EDGE_W = 4 * CW + 2;

  logic       adv;
  logic       s1_valid, s2_valid, s3_valid;
  pip_ctrl_t  s1_ctrl, s2_ctrl;
  logic       s3_last;
  logic [1:0] s3_cross;
  logic [1:0] cross_next;
  logic       parity;
  logic       parity_new;

  assign adv = !out_valid || out_ready;
  assign pop = adv && !q_empty;

  for (genvar e = 0; e < 2; e++) begin : g_lane
    logic signed [XW-1:0] x, y;
    logic signed [CW-1:0] dl, el;
    logic signed [H:0]    dl_lo, el_lo;
    logic signed [CW-H-1:0] dl_hi, el_hi;
    logic signed [LW-1:0] s1_pxl, s1_pyl;
    logic signed [HW-1:0] s1_pxh, s1_pyh;
    logic                 s1_neg, s2_neg;
    logic signed [PW-1:0] s2_px, s2_py;
    logic signed [PW:0]   diff;

    assign x     = $signed(pop_data[e*EDGE_W + EDGE_W - 1 -: XW]);
    assign y     = $signed(pop_data[e*EDGE_W + 2*CW +: XW]);
    assign dl    = $signed(pop_data[e*EDGE_W + CW +: CW]);
    assign el    = $signed(pop_data[e*EDGE_W +: CW]);
    assign dl_lo = $signed({1'b0, dl[H-1:0]});
    assign el_lo = $signed({1'b0, el[H-1:0]});
    assign dl_hi = $signed(dl[CW-1:H]);
    assign el_hi = $signed(el[CW-1:H]);

    // partial products, then full products
    always_ff @(posedge clk) begin
      if (adv) begin
        s1_pxl <= x * dl_lo;
        s1_pxh <= x * dl_hi;
        s1_pyl <= y * el_lo;
        s1_pyh <= y * el_hi;
        s1_neg <= dl[CW-1];
        s2_px  <= (PW'(s1_pxh) <<< H) + PW'(s1_pxl);
        s2_py  <= (PW'(s1_pyh) <<< H) + PW'(s1_pyl);
        s2_neg <= s1_neg;
      end
    end

    // cross when (y*el - x*dl) has the sign of dl
    assign diff = (PW + 1)'(s2_py) - (PW + 1)'(s2_px);
    assign cross_next[e] = s2_ctrl.act[e] &&
                           (s2_neg ? diff[PW] : (!diff[PW] && diff != '0));
  end

  assign parity_new = parity ^ s3_cross[0] ^ s3_cross[1];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctrl  <= pop_ctrl;
      s2_ctrl  <= s1_ctrl;
      s3_cross <= cross_next;
      s3_last  <= s2_ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      parity    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= pop;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid && s3_last;
      if (s3_valid) begin
        parity <= s3_last ? 1'b0 : parity_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid && s3_last) begin
      inside_res <= parity_new;
    end
  end

`ifndef ASSERT_OFF
  a_parity_cleared: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !parity)
    else $error("parity not cleared with result");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv && s3_valid |=> s3_valid && $stable(s3_cross))
    else $error("last stage moved while output stalled");
`endif

endmodule

>>> hw/rtl/point_in_polygon_test.sv
// Top level of the point-in-polygon test: configuration registers and block wiring.
//
// Even-odd ray-casting test of a query point (query_lat, query_lon, degrees
// times 1e7) against a polygon streamed one vertex word per cycle. The front
// end accepts a vertex, keeps the first and previous vertex and forms the
// differences for the edge to the previous vertex and, on a last_vertex word,
// for the closing edge to the first vertex. A queue of QUEUE_DEPTH words feeds
// the back end, which forms both edge tests exactly by cross-multiplication
// (each product split into two partial products in one stage, summed in the
// next, compared in the third), folds the crossings into a parity bit and
// loads inside_res into the output register on the last vertex. Sustained
// rate is one vertex word per cycle; the back end stalls only while a result
// waits in the output register, and the front end keeps accepting until the
// queue fills. A result passes through s1, s2 and s3 into the output register.
// A polygon of one vertex reports 0. Write query registers only while idle:
// they are sampled when a vertex word is taken.
module point_in_polygon_test #(
  parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF,
  parameter int QUEUE_DEPTH = pip_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pip_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [COORD_WIDTH-1:0]            cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-2:0]     vertex_lat,
  input  logic signed [COORD_WIDTH-1:0]     vertex_lon,
  input  logic                              last_vertex,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              inside_res
);
  import pip_pkg::*;

  localparam int DATA_W = 2 * (4 * COORD_WIDTH + 2);

  logic signed [COORD_WIDTH-2:0] query_lat;
  logic signed [COORD_WIDTH-1:0] query_lon;

  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  logic [DATA_W-1:0] push_data;
  logic [DATA_W-1:0] pop_data;
  pip_ctrl_t         push_ctrl;
  pip_ctrl_t         pop_ctrl;

  // Query point registers; latitude keeps the low bits of the write data.
  always_ff @(posedge clk) begin
    if (rst) begin
      query_lat <= '0;
      query_lon <= '0;
    end else if (cfg_we) begin
      case (pip_reg_t'(cfg_addr))
        REG_QUERY_LAT: query_lat <= $signed(cfg_wdata[COORD_WIDTH-2:0]);
        REG_QUERY_LON: query_lon <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Accept vertices and classify edges.
  pip_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .query_lat   (query_lat),
    .query_lon   (query_lon),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .vertex_lat  (vertex_lat),
    .vertex_lon  (vertex_lon),
    .last_vertex (last_vertex),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data),
    .push_ctrl   (push_ctrl)
  );

  // Decouple front and back so each can stall on its own.
  pip_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .push_ctrl (push_ctrl),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .pop_ctrl  (pop_ctrl),
    .empty     (q_empty)
  );

  // Multiply, compare, accumulate parity and hold the result word.
  pip_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .pop        (pop),
    .pop_data   (pop_data),
    .pop_ctrl   (pop_ctrl),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .inside_res (inside_res)
  );

endmodule
